// ===== sv/backslash_hex_escape_decoder_assert.svh =====
// assertion macros for the escape decoder checker
`ifndef BACKSLASH_HEX_ESCAPE_DECODER_ASSERT_SVH
`define BACKSLASH_HEX_ESCAPE_DECODER_ASSERT_SVH

// property checked while out of reset
`define BHD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define BHD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/bhd_pkg.sv =====
`default_nettype none
package bhd_pkg;

    typedef enum logic [2:0] {
        MODE_PLAIN  = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_HEX_HI = 3'd2,
        MODE_HEX_LO = 3'd3,
        MODE_SKIP   = 3'd4
    } t_mode;

    localparam logic [1:0] ST_GOING  = 2'd0;
    localparam logic [1:0] ST_DONE   = 2'd1;
    localparam logic [1:0] ST_BAD    = 2'd2;
    localparam logic [1:0] ST_FAILED = 2'd3;

    localparam logic [7:0] CHAR_BSLASH = 8'h5c;
    localparam logic [7:0] CHAR_X      = 8'h78;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_LA     = 8'h61;
    localparam logic [7:0] CHAR_LZ     = 8'h7a;
    localparam logic [7:0] CHAR_UA     = 8'h41;
    localparam logic [7:0] CHAR_UZ     = 8'h5a;
    localparam logic [7:0] DIGIT_TEN   = 8'h0a;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] byte_out;
        logic [1:0] status;
    } t_out_word;

    // digit value with no range check, wraps mod 256
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        if (c inside {[CHAR_LA:CHAR_LZ]}) begin
            v = c - CHAR_LA + DIGIT_TEN;
        end else if (c inside {[CHAR_UA:CHAR_UZ]}) begin
            v = c - CHAR_UA + DIGIT_TEN;
        end else begin
            v = c - CHAR_ZERO;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== sv/bhd_if.sv =====
`default_nettype none
interface bhd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink (input valid, input ch, input last, output ready);
endinterface

interface bhd_out_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] byte_out;
    logic [1:0] status;

    modport source (output valid, output has_byte, output byte_out, output status,
                    input ready);
    modport sink (input valid, input has_byte, input byte_out, input status,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/bhd_in_reg.sv =====
`default_nettype none
module bhd_in_reg
    import bhd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_word i_word,
    output logic          o_ready,
    input  wire logic     i_take,
    output logic          o_valid,
    output t_in_word      o_word
);

    logic     r_valid;
    t_in_word r_word;

    // room when empty or when the held word moves on this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule
`default_nettype wire

// ===== sv/bhd_decode.sv =====
`default_nettype none
module bhd_decode
    import bhd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_fire,
    input  wire t_in_word i_word,
    output t_out_word     o_word
);

    t_mode      r_mode, n_mode;
    logic [7:0] r_high, n_high;
    logic [7:0] digit;

    assign digit = digit_value(i_word.ch);

    always_comb begin
        n_mode          = r_mode;
        n_high          = r_high;
        o_word.has_byte = 1'b0;
        o_word.byte_out = 8'h00;
        o_word.status   = ST_GOING;
        case (r_mode)
            MODE_ESC: begin
                if (i_word.ch == CHAR_BSLASH) begin
                    o_word.has_byte = 1'b1;
                    o_word.byte_out = CHAR_BSLASH;
                    n_mode          = MODE_PLAIN;
                    o_word.status   = i_word.last ? ST_DONE : ST_GOING;
                end else if (i_word.ch == CHAR_X) begin
                    n_mode        = MODE_HEX_HI;
                    o_word.status = i_word.last ? ST_FAILED : ST_GOING;
                end else begin
                    n_mode        = MODE_SKIP;
                    o_word.status = i_word.last ? ST_FAILED : ST_BAD;
                end
            end
            MODE_HEX_HI: begin
                n_high        = {digit[3:0], 4'h0};
                n_mode        = MODE_HEX_LO;
                o_word.status = i_word.last ? ST_FAILED : ST_GOING;
            end
            MODE_HEX_LO: begin
                o_word.has_byte = 1'b1;
                o_word.byte_out = r_high + digit;
                n_mode          = MODE_PLAIN;
                o_word.status   = i_word.last ? ST_DONE : ST_GOING;
            end
            MODE_SKIP: begin
                o_word.status = i_word.last ? ST_FAILED : ST_GOING;
            end
            default: begin
                if (i_word.ch == CHAR_BSLASH) begin
                    n_mode        = MODE_ESC;
                    o_word.status = i_word.last ? ST_FAILED : ST_GOING;
                end else begin
                    o_word.has_byte = 1'b1;
                    o_word.byte_out = i_word.ch;
                    n_mode          = MODE_PLAIN;
                    o_word.status   = i_word.last ? ST_DONE : ST_GOING;
                end
            end
        endcase
        // end of string always restarts in plain mode
        if (i_word.last) begin
            n_mode = MODE_PLAIN;
            n_high = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PLAIN;
            r_high <= 8'h00;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_high <= n_high;
        end
    end

endmodule
`default_nettype wire

// ===== sv/bhd_out_reg.sv =====
`default_nettype none
module bhd_out_reg
    import bhd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire t_out_word i_word,
    output logic           o_take,
    input  wire logic      i_ready,
    output logic           o_valid,
    output t_out_word      o_word
);

    logic      r_valid;
    t_out_word r_word;

    assign o_take = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
        if (o_take && i_valid) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule
`default_nettype wire

// ===== sv/backslash_hex_escape_decoder.sv =====
`default_nettype none
// Backslash hex escape decoder: takes one character of an escaped string per
// word on i_in and gives one result word per character on o_out (has_byte,
// byte_out, status). Plain characters pass through, "\\" gives a backslash,
// "\xHL" gives one byte; any other escape reports a bad escape and the rest
// of the string is dropped. A new character is taken every cycle while the
// sink keeps ready high; a character passes the input register and then the
// result register, with the decode and mode update between them. The decode
// state returns to plain mode after each word marked last.
module backslash_hex_escape_decoder
    import bhd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bhd_in_if.sink     i_in,
    bhd_out_if.source  o_out
);

    t_in_word  in_word, held_word;
    t_out_word dec_word, res_word;
    logic      held_valid, take, res_valid, in_ready;

    assign in_word.ch   = i_in.ch;
    assign in_word.last = i_in.last;
    assign i_in.ready   = in_ready;

    bhd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_word  (in_word),
        .o_ready (in_ready),
        .i_take  (take),
        .o_valid (held_valid),
        .o_word  (held_word)
    );

    bhd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (held_valid && take),
        .i_word  (held_word),
        .o_word  (dec_word)
    );

    bhd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (held_valid),
        .i_word  (dec_word),
        .o_take  (take),
        .i_ready (o_out.ready),
        .o_valid (res_valid),
        .o_word  (res_word)
    );

    assign o_out.valid    = res_valid;
    assign o_out.has_byte = res_word.has_byte;
    assign o_out.byte_out = res_word.byte_out;
    assign o_out.status   = res_word.status;

endmodule
`default_nettype wire

// ===== sv/bhd_checker.sv =====
`default_nettype none
`include "backslash_hex_escape_decoder_assert.svh"
module bhd_checker
    import bhd_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_has_byte,
    input wire logic [7:0] i_byte_out,
    input wire logic [1:0] i_status
);

    `BHD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

    `BHD_ASSERT(a_no_byte_zero, i_clk, i_rst_n, (i_out_valid && !i_has_byte) |-> (i_byte_out == 8'h00), "byte_out nonzero without a byte")

    `BHD_ASSERT(a_err_no_byte, i_clk, i_rst_n, (i_out_valid && (i_status == ST_BAD || i_status == ST_FAILED)) |-> !i_has_byte, "byte given with error status")

    // stalled word holds
    `BHD_ASSERT(a_stall_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_status) && $stable(i_byte_out) && $stable(i_has_byte)), "stalled result changed")

endmodule

bind backslash_hex_escape_decoder bhd_checker u_bhd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_has_byte  (o_out.has_byte),
    .i_byte_out  (o_out.byte_out),
    .i_status    (o_out.status)
);
`default_nettype wire

// ===== tb/sv/backslash_hex_escape_decoder_test.sv =====
`timescale 1ns / 100ps
module backslash_hex_escape_decoder_test;
    import bhd_pkg::*;

    localparam int RANDOM_WORDS = 950;
    localparam int CALM_WORDS   = 150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 150;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
        bit         typed;
        t_out_word  want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    bhd_in_if  in_w ();
    bhd_out_if out_w ();

    backslash_hex_escape_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_w),
        .o_out   (out_w)
    );

    // decoder state as the testbench sees it
    t_mode      dec_mode;
    logic [7:0] dec_high;

    t_out_word  expected_results [$];
    t_stim_row  directed_rows [25];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         sent_count = 0;
    bit         calm = 0;
    bit         no_gaps = 0;
    bit         hold_req = 0;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic logic [7:0] digit_worth(input logic [7:0] c);
        logic [7:0] base;
        logic [7:0] bias;
        if (c >= CHAR_LA && c <= CHAR_LZ) begin
            base = CHAR_LA;
            bias = DIGIT_TEN;
        end else if (c >= CHAR_UA && c <= CHAR_UZ) begin
            base = CHAR_UA;
            bias = DIGIT_TEN;
        end else begin
            base = CHAR_ZERO;
            bias = 8'd0;
        end
        return 8'(c - base) + bias;
    endfunction

    // advances the decoder state by one character and gives its result word
    function automatic t_out_word decode_char(input logic [7:0] c, input logic fin);
        t_out_word r;
        logic [7:0] d;
        r = '0;
        r.status = ST_GOING;
        d = digit_worth(c);
        case (dec_mode)
            MODE_ESC: begin
                if (c == CHAR_BSLASH) begin
                    r.has_byte = 1'b1;
                    r.byte_out = CHAR_BSLASH;
                    dec_mode = MODE_PLAIN;
                    r.status = fin ? ST_DONE : ST_GOING;
                end else if (c == CHAR_X) begin
                    dec_mode = MODE_HEX_HI;
                    r.status = fin ? ST_FAILED : ST_GOING;
                end else begin
                    dec_mode = MODE_SKIP;
                    r.status = fin ? ST_FAILED : ST_BAD;
                end
            end
            MODE_HEX_HI: begin
                dec_high = d << 4;
                dec_mode = MODE_HEX_LO;
                r.status = fin ? ST_FAILED : ST_GOING;
            end
            MODE_HEX_LO: begin
                r.has_byte = 1'b1;
                r.byte_out = dec_high + d;
                dec_mode = MODE_PLAIN;
                r.status = fin ? ST_DONE : ST_GOING;
            end
            MODE_SKIP: begin
                r.status = fin ? ST_FAILED : ST_GOING;
            end
            default: begin
                if (c == CHAR_BSLASH) begin
                    dec_mode = MODE_ESC;
                    r.status = fin ? ST_FAILED : ST_GOING;
                end else begin
                    r.has_byte = 1'b1;
                    r.byte_out = c;
                    dec_mode = MODE_PLAIN;
                    r.status = fin ? ST_DONE : ST_GOING;
                end
            end
        endcase
        if (fin) begin
            dec_mode = MODE_PLAIN;
            dec_high = 8'd0;
        end
        return r;
    endfunction

    function automatic logic [7:0] random_digit_char();
        int r;
        r = $urandom_range(0, 31);
        if (r < 10) begin
            return CHAR_ZERO + 8'(r);
        end else if (r < 16) begin
            return CHAR_LA + 8'(r - 10);
        end else if (r < 22) begin
            return CHAR_UA + 8'(r - 16);
        end else begin
            return 8'($urandom_range(0, 255));
        end
    endfunction

    task automatic send_word(input logic [7:0] c, input logic fin, input bit typed,
                             input t_out_word want);
        t_out_word guess;
        if (!calm && !no_gaps && $urandom_range(0, 7) == 0) begin
            in_w.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_w.valid <= 1'b1;
        in_w.ch    <= c;
        in_w.last  <= fin;
        do @(posedge i_clk); while (!in_w.ready);
        guess = decode_char(c, fin);
        if (typed) guess = want;
        expected_results = {expected_results, guess};
        sent_count++;
    endtask

    task automatic send_random_string();
        logic [7:0] txt [$];
        logic [7:0] b;
        int kind;
        int n;
        int k;
        int i;
        kind = $urandom_range(0, 19);
        if (kind >= 18) begin
            // noise: anything at all
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++) txt = {txt, 8'($urandom_range(0, 255))};
        end else begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++) begin
                k = $urandom_range(0, 5);
                if (k <= 2) begin
                    b = 8'($urandom_range(0, 255));
                    txt = {txt, b};
                    if (b == CHAR_BSLASH) txt = {txt, CHAR_BSLASH};
                end else if (k == 3) begin
                    txt = {txt, CHAR_BSLASH};
                    txt = {txt, CHAR_BSLASH};
                end else begin
                    txt = {txt, CHAR_BSLASH};
                    txt = {txt, CHAR_X};
                    txt = {txt, random_digit_char()};
                    txt = {txt, random_digit_char()};
                end
            end
            if (kind >= 14 && kind <= 15) begin
                // bad escape, possibly followed by characters to be dropped
                do b = 8'($urandom_range(0, 255));
                while (b == CHAR_BSLASH || b == CHAR_X);
                txt = {txt, CHAR_BSLASH};
                txt = {txt, b};
                n = $urandom_range(0, 3);
                for (i = 0; i < n; i++) txt = {txt, 8'($urandom_range(0, 255))};
            end else if (kind >= 16 && kind <= 17) begin
                // string cut off inside an escape
                txt = {txt, CHAR_BSLASH};
                k = $urandom_range(0, 2);
                if (k >= 1) txt = {txt, CHAR_X};
                if (k == 2) txt = {txt, random_digit_char()};
            end
        end
        for (i = 0; i < txt.size(); i++) begin
            send_word(txt[i], i == txt.size() - 1, 1'b0, '0);
        end
    endtask

    // receiver side: random stalls plus one long hold-off on request
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        out_w.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_w.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_w.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                out_w.ready <= 1'b0;
            end else begin
                out_w.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && out_w.valid && out_w.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected word, expected none, got has_byte %0b byte %02h st %0d",
                         $time, out_w.has_byte, out_w.byte_out, out_w.status);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (out_w.has_byte !== want.has_byte) begin
                    $display("%0t: has_byte mismatch, expected %0b, got %0b",
                             $time, want.has_byte, out_w.has_byte);
                    mismatch_count++;
                end
                if (out_w.byte_out !== want.byte_out) begin
                    $display("%0t: byte_out mismatch, expected %02h, got %02h",
                             $time, want.byte_out, out_w.byte_out);
                    mismatch_count++;
                end
                if (out_w.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, out_w.status);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int i;
        int total;
        bit hold_done;
        bit pause_done;
        logic [7:0] b;
        hold_done = 0;
        pause_done = 0;
        dec_mode = MODE_PLAIN;
        dec_high = 8'd0;
        in_w.valid <= 1'b0;
        in_w.ch    <= 8'd0;
        in_w.last  <= 1'b0;
        i_rst_n    <= 1'b0;

        directed_rows = '{
            '{"A",         1'b0, 1'b1, {1'b1, 8'h41, ST_GOING}},
            '{8'h00,       1'b0, 1'b1, {1'b1, 8'h00, ST_GOING}},
            '{8'hff,       1'b1, 1'b1, {1'b1, 8'hff, ST_DONE}},
            '{CHAR_BSLASH, 1'b0, 1'b1, {1'b0, 8'h00, ST_GOING}},
            '{CHAR_BSLASH, 1'b1, 1'b1, {1'b1, CHAR_BSLASH, ST_DONE}},
            '{CHAR_BSLASH, 1'b0, 1'b0, '0},
            '{CHAR_X,      1'b0, 1'b0, '0},
            '{"F",         1'b0, 1'b0, '0},
            '{"f",         1'b1, 1'b0, '0},
            '{CHAR_BSLASH, 1'b0, 1'b0, '0},
            '{"q",         1'b0, 1'b1, {1'b0, 8'h00, ST_BAD}},
            '{"z",         1'b0, 1'b1, {1'b0, 8'h00, ST_GOING}},
            '{"y",         1'b1, 1'b1, {1'b0, 8'h00, ST_FAILED}},
            '{CHAR_BSLASH, 1'b0, 1'b0, '0},
            '{"k",         1'b1, 1'b1, {1'b0, 8'h00, ST_FAILED}},
            '{CHAR_BSLASH, 1'b1, 1'b1, {1'b0, 8'h00, ST_FAILED}},
            '{CHAR_BSLASH, 1'b0, 1'b0, '0},
            '{CHAR_X,      1'b1, 1'b1, {1'b0, 8'h00, ST_FAILED}},
            '{CHAR_BSLASH, 1'b0, 1'b0, '0},
            '{CHAR_X,      1'b0, 1'b0, '0},
            '{"7",         1'b1, 1'b1, {1'b0, 8'h00, ST_FAILED}},
            '{CHAR_BSLASH, 1'b0, 1'b0, '0},
            '{CHAR_X,      1'b0, 1'b0, '0},
            '{8'hff,       1'b0, 1'b0, '0},
            '{8'h00,       1'b1, 1'b0, '0}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < 25; i++) begin
            send_word(directed_rows[i].ch, directed_rows[i].fin, directed_rows[i].typed,
                      directed_rows[i].want);
        end

        total = sent_count + RANDOM_WORDS;
        while (sent_count < total) begin
            if (!hold_done && sent_count >= 330) begin
                // receiver holds off while words keep coming, so the input backs up
                hold_done = 1;
                hold_req = 1'b1;
                no_gaps = 1'b1;
                for (i = 0; i < 40; i++) begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CHAR_BSLASH) b = CHAR_X;
                    send_word(b, i == 39, 1'b0, '0);
                end
                no_gaps = 1'b0;
            end
            if (!pause_done && sent_count >= 640) begin
                pause_done = 1;
                in_w.valid <= 1'b0;
                while (expected_results.size() != 0) @(posedge i_clk);
            end
            if (sent_count >= total - CALM_WORDS) calm = 1'b1;
            send_random_string();
        end
        in_w.valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/bhd_pkg.sv
sv/bhd_if.sv
sv/bhd_in_reg.sv
sv/bhd_decode.sv
sv/bhd_out_reg.sv
sv/backslash_hex_escape_decoder.sv
sv/bhd_checker.sv
tb/sv/backslash_hex_escape_decoder_test.sv
